FILE: src/phv_pkg.sv
package phv_pkg;

  localparam int CH_W = 8;

  // Hue in 1/64 degree steps.
  localparam int HUE_SECTOR = 3840;
  localparam int HUE_GREEN  = 7680;
  localparam int HUE_BLUE   = 15360;
  localparam int HUE_FULL   = 23040;

  // Shared shape of both dividers: an 8-bit divisor, a 24-bit dividend and
  // a 17-bit quotient, one quotient bit per pipeline stage.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_QUO_W = 17;

  // Register stages behind the dividers.
  localparam int BACK_DEPTH = 5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HUE_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_SAT_GAIN   = 2'd1;
  localparam logic [1:0] CFG_VALUE_GAIN = 2'd2;

  localparam logic [15:0] GAIN_ONE = 16'd4096;

  // Per-pixel data that travels beside the dividers.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic [16:0]     value;
    logic [14:0]     base;
    logic            neg;
    logic            gray;
  } side_t;

endpackage

FILE: src/phv_div.sv
module phv_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8,
  parameter int QUO_W = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  // Restoring division, one quotient bit per stage. The caller guarantees
  // that the quotient fits in QUO_W bits.
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] prem;
    logic [QUO_W-1:0] plow;
    logic [QUO_W-1:0] pquo;
    logic [DEN_W-1:0] pden;
    logic [DEN_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_first
      assign prem = DEN_W'(num_i >> QUO_W);
      assign plow = num_i[QUO_W-1:0];
      assign pquo = '0;
      assign pden = den_i;
    end else begin : g_next
      assign prem = rem_q[k-1];
      assign plow = low_q[k-1];
      assign pquo = quo_q[k-1];
      assign pden = den_q[k-1];
    end

    assign trial = {prem, plow[QUO_W-1]};
    assign take  = (trial >= {1'b0, pden});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DEN_W'(trial - {1'b0, pden}) : trial[DEN_W-1:0];
        low_q[k] <= plow << 1;
        quo_q[k] <= {pquo[QUO_W-2:0], take};
        den_q[k] <= pden;
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

FILE: src/phv_front.sv
module phv_front (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         alpha_i,
  output logic [23:0]        sat_num_o,
  output logic [7:0]         sat_den_o,
  output logic [23:0]        hue_num_o,
  output logic [7:0]         hue_den_o,
  output phv_pkg::side_t     side_o
);

  logic [7:0]  mx, mn, delta, mag;
  logic [14:0] base;
  logic        neg;
  logic [16:0] value;

  logic [23:0]    sat_num_q, hue_num_q;
  logic [7:0]     sat_den_q, hue_den_q;
  phv_pkg::side_t side_q;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;

    // Red wins ties, then green.
    if (red_i == mx) begin
      neg  = !(green_i > blue_i);
      mag  = neg ? blue_i - green_i : green_i - blue_i;
      base = neg ? 15'(phv_pkg::HUE_FULL) : 15'd0;
    end else if (green_i == mx) begin
      neg  = (blue_i < red_i);
      mag  = neg ? red_i - blue_i : blue_i - red_i;
      base = 15'(phv_pkg::HUE_GREEN);
    end else begin
      neg  = (red_i < green_i);
      mag  = neg ? green_i - red_i : red_i - green_i;
      base = 15'(phv_pkg::HUE_BLUE);
    end

    // max * 65536 / 255 equals max * 257, plus one at full scale.
    value = 17'(mx) * 17'd257 + ((mx == 8'hff) ? 17'd1 : 17'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_num_q <= {delta, 16'd0};
      sat_den_q <= mx;
      hue_num_q <= 24'(mag) * 24'(phv_pkg::HUE_SECTOR);
      hue_den_q <= delta;
      side_q    <= '{red: red_i, green: green_i, blue: blue_i, alpha: alpha_i,
                     value: value, base: base, neg: neg, gray: (delta == 8'd0)};
    end
  end

  assign sat_num_o = sat_num_q;
  assign sat_den_o = sat_den_q;
  assign hue_num_o = hue_num_q;
  assign hue_den_o = hue_den_q;
  assign side_o    = side_q;

endmodule

FILE: src/phv_back.sv
module phv_back (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [16:0]    sat_quo_i,
  input  logic [16:0]    hue_quo_i,
  input  phv_pkg::side_t side_i,
  input  logic [15:0]    hue_shift_i,
  input  logic [15:0]    sat_gain_i,
  input  logic [15:0]    value_gain_i,
  output logic [7:0]     red_o,
  output logic [7:0]     green_o,
  output logic [7:0]     blue_o,
  output logic [7:0]     alpha_o
);

  localparam logic [27:0] FULL_T = 28'(65536 * phv_pkg::HUE_SECTOR);

  // round(255 * v * t / (2^32 * 3840)) reduces to round(17 * v * t / 2^40).
  function automatic logic [7:0] scale(input logic [44:0] p);
    logic [49:0] x;
    x = 50'(p) * 50'd17 + (50'd1 << 39);
    return x[47:40];
  endfunction

  // Stage C: hue assembly and shift, gain products.
  logic signed [17:0] h0, hsum, hwrap;
  logic signed [17:0] h_c_q;
  logic [32:0]        sp_c_q, vp_c_q;
  phv_pkg::side_t     side_c_q;

  always_comb begin
    if (side_i.gray) h0 = '0;
    else if (side_i.neg) h0 = $signed({3'b0, side_i.base}) - $signed({1'b0, hue_quo_i});
    else h0 = $signed({3'b0, side_i.base}) + $signed({1'b0, hue_quo_i});
    hsum = h0 + $signed({{2{hue_shift_i[15]}}, hue_shift_i});
    if (hsum > 18'sd23040) hwrap = hsum - 18'sd23040;
    else if (hsum < 0) hwrap = hsum + 18'sd23040;
    else hwrap = hsum;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_c_q    <= hwrap;
      sp_c_q   <= 33'(side_i.gray ? 17'd0 : sat_quo_i) * 33'(sat_gain_i);
      vp_c_q   <= 33'(side_i.value) * 33'(value_gain_i);
      side_c_q <= side_i;
    end
  end

  // Stage D: caps, sector and fraction.
  logic [20:0] sp, vp;
  logic [16:0] hu;
  logic [3:0]  cnt;
  logic [16:0] s_d_q, v_d_q;
  logic [11:0] f_d_q;
  logic [2:0]  sec_d_q;
  logic        ok_d_q;
  phv_pkg::side_t side_d_q;

  always_comb begin
    sp  = sp_c_q[32:12];
    vp  = vp_c_q[32:12];
    hu  = h_c_q[16:0];
    cnt = '0;
    for (int k = 1; k <= 8; k++) begin
      if (hu >= 17'(k * phv_pkg::HUE_SECTOR)) cnt = cnt + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_d_q    <= (sp > 21'd65536) ? 17'd65536 : sp[16:0];
      v_d_q    <= (vp > 21'd65536) ? 17'd65536 : vp[16:0];
      f_d_q    <= 12'(hu - 17'(cnt) * 17'(phv_pkg::HUE_SECTOR));
      // Sector 6 is sector 0; negative hue or sectors past 6 pass through.
      ok_d_q   <= !h_c_q[17] && (cnt <= 4'd6);
      sec_d_q  <= (cnt == 4'd6) ? 3'd0 : cnt[2:0];
      side_d_q <= side_c_q;
    end
  end

  // Stage E: the three partial terms.
  logic [27:0] t_v1s_e_q, t_vsf_e_q, t_v1f_e_q;
  logic [16:0] v_e_q;
  logic [2:0]  sec_e_q;
  logic        ok_e_q;
  phv_pkg::side_t side_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_v1s_e_q <= 28'(17'd65536 - s_d_q) * 28'(phv_pkg::HUE_SECTOR);
      t_vsf_e_q <= FULL_T - 28'(s_d_q) * 28'(f_d_q);
      t_v1f_e_q <= FULL_T - 28'(s_d_q) * 28'(12'(phv_pkg::HUE_SECTOR) - f_d_q);
      v_e_q     <= v_d_q;
      sec_e_q   <= sec_d_q;
      ok_e_q    <= ok_d_q;
      side_e_q  <= side_d_q;
    end
  end

  // Stage F: value times each term.
  logic [44:0] p_full_q, p_v1s_q, p_vsf_q, p_v1f_q;
  logic [2:0]  sec_f_q;
  logic        ok_f_q;
  phv_pkg::side_t side_f_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_full_q <= 45'(v_e_q) * 45'(FULL_T);
      p_v1s_q  <= 45'(v_e_q) * 45'(t_v1s_e_q);
      p_vsf_q  <= 45'(v_e_q) * 45'(t_vsf_e_q);
      p_v1f_q  <= 45'(v_e_q) * 45'(t_v1f_e_q);
      sec_f_q  <= sec_e_q;
      ok_f_q   <= ok_e_q;
      side_f_q <= side_e_q;
    end
  end

  // Stage G: rounding and channel selection.
  logic [7:0] c_full, c_v1s, c_vsf, c_v1f;
  logic [7:0] r_g, g_g, b_g;
  logic [7:0] red_q, green_q, blue_q, alpha_q;

  always_comb begin
    c_full = scale(p_full_q);
    c_v1s  = scale(p_v1s_q);
    c_vsf  = scale(p_vsf_q);
    c_v1f  = scale(p_v1f_q);
    r_g = side_f_q.red;
    g_g = side_f_q.green;
    b_g = side_f_q.blue;
    if (ok_f_q) begin
      unique case (sec_f_q)
        3'd0: begin r_g = c_full; g_g = c_v1f;  b_g = c_v1s;  end
        3'd1: begin r_g = c_vsf;  g_g = c_full; b_g = c_v1s;  end
        3'd2: begin r_g = c_v1s;  g_g = c_full; b_g = c_v1f;  end
        3'd3: begin r_g = c_v1s;  g_g = c_vsf;  b_g = c_full; end
        3'd4: begin r_g = c_v1f;  g_g = c_v1s;  b_g = c_full; end
        3'd5: begin r_g = c_full; g_g = c_v1s;  b_g = c_vsf;  end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= r_g;
      green_q <= g_g;
      blue_q  <= b_g;
      alpha_q <= side_f_q.alpha;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = alpha_q;

endmodule

FILE: src/pixel_hsv_tint.sv
// HSV tint of an 8-bit ARGB pixel stream. Each transfer on the input side
// yields exactly one transfer on the output side, in order. The block is a
// fully pipelined datapath that takes one pixel per clock while the output
// is not stalled: one front stage that finds the dominant channel, two
// 17-stage pipelined dividers (saturation and hue fraction) running in
// parallel, and five back stages for the hue shift, gains, the six-sector
// back conversion and the output register. The pipeline moves as a whole:
// when the output holds a pixel and out_stall_i is high, every stage holds
// and in_stall_o is raised, so nothing is dropped or repeated. hue_shift,
// saturation_gain and value_gain are written through the cfg port at any
// edge with cfg_we_i high and must only change while no pixel is in
// flight. Alpha is carried through untouched.
module pixel_hsv_tint (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  alpha_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int LAT = 1 + phv_pkg::DIV_QUO_W + phv_pkg::BACK_DEPTH;

  logic [15:0] hue_shift_q, sat_gain_q, value_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_shift_q  <= '0;
      sat_gain_q   <= phv_pkg::GAIN_ONE;
      value_gain_q <= phv_pkg::GAIN_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        phv_pkg::CFG_HUE_SHIFT:  hue_shift_q  <= cfg_data_i;
        phv_pkg::CFG_SAT_GAIN:   sat_gain_q   <= cfg_data_i;
        phv_pkg::CFG_VALUE_GAIN: value_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished pixel is held at the output.
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en = !vld_q[LAT-1] || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic [23:0]    sat_num, hue_num;
  logic [7:0]     sat_den, hue_den;
  logic [16:0]    sat_quo, hue_quo;
  phv_pkg::side_t side_a;

  phv_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .red_i     (red_in_i),
    .green_i   (green_in_i),
    .blue_i    (blue_in_i),
    .alpha_i   (alpha_in_i),
    .sat_num_o (sat_num),
    .sat_den_o (sat_den),
    .hue_num_o (hue_num),
    .hue_den_o (hue_den),
    .side_o    (side_a)
  );

  phv_div #(
    .NUM_W (phv_pkg::DIV_NUM_W),
    .DEN_W (phv_pkg::DIV_DEN_W),
    .QUO_W (phv_pkg::DIV_QUO_W)
  ) u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sat_num),
    .den_i (sat_den),
    .quo_o (sat_quo)
  );

  phv_div #(
    .NUM_W (phv_pkg::DIV_NUM_W),
    .DEN_W (phv_pkg::DIV_DEN_W),
    .QUO_W (phv_pkg::DIV_QUO_W)
  ) u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (hue_num),
    .den_i (hue_den),
    .quo_o (hue_quo)
  );

  // Side data rides beside the dividers so it meets their quotients.
  phv_pkg::side_t side_q [phv_pkg::DIV_QUO_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_a;
      for (int k = 1; k < phv_pkg::DIV_QUO_W; k++) side_q[k] <= side_q[k-1];
    end
  end

  phv_back u_back (
    .clk_i        (clk_i),
    .en_i         (en),
    .sat_quo_i    (sat_quo),
    .hue_quo_i    (hue_quo),
    .side_i       (side_q[phv_pkg::DIV_QUO_W-1]),
    .hue_shift_i  (hue_shift_q),
    .sat_gain_i   (sat_gain_q),
    .value_gain_i (value_gain_q),
    .red_o        (red_out_o),
    .green_o      (green_out_o),
    .blue_o       (blue_out_o),
    .alpha_o      (alpha_out_o)
  );

  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

endmodule
